// ===== sv/cimrc_pkg.sv =====
package cimrc_pkg;

    localparam int DATA_WIDTH        = 32;
    localparam int INDEX_WIDTH_DEF   = 32;
    localparam int LANES             = 4;
    localparam int QUEUE_DEPTH_DEF   = 2;
    localparam int S_TDATA_WIDTH     = LANES * DATA_WIDTH;
    localparam int M_TDATA_WIDTH     = 80;
    localparam int ROUTE_WIDTH       = 3;

    typedef enum logic [2:0] {
        ROUTE_A      = 3'd0,
        ROUTE_B      = 3'd1,
        ROUTE_SAVED_A = 3'd2,
        ROUTE_SAVED_B = 3'd3,
        ROUTE_NEXT_A = 3'd4,
        ROUTE_NEXT_B = 3'd5
    } route_t;

    typedef enum logic [1:0] {
        KIND_GROUP  = 2'd0,
        KIND_SECOND = 2'd1,
        KIND_TERM   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_GROUP,
        PH_SECOND,
        PH_TERM
    } phase_t;

    typedef struct packed {
        route_t route_0;
        route_t route_1;
        route_t route_2;
        route_t route_3;
        logic   split;
        logic   term;
    } cmd_ctrl_t;

    localparam int CTRL_WIDTH = $bits(cmd_ctrl_t);

endpackage

// ===== sv/cimrc_queue.sv =====
module cimrc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/cimrc_front.sv =====
module cimrc_front #(
    parameter int INDEX_WIDTH = cimrc_pkg::INDEX_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [cimrc_pkg::DATA_WIDTH-1:0]     cfg_data,
    input  logic                                 in_valid,
    input  logic [cimrc_pkg::S_TDATA_WIDTH-1:0]  in_data,
    output logic                                 in_ready,
    input  logic                                 queue_full,
    output logic                                 push,
    output cimrc_pkg::cmd_ctrl_t                 cmd_ctrl,
    output logic [INDEX_WIDTH-1:0]               cmd_fetch_a,
    output logic [INDEX_WIDTH-1:0]               cmd_fetch_b,
    output logic [INDEX_WIDTH-1:0]               cmd_second_a,
    output logic [INDEX_WIDTH-1:0]               cmd_second_b
);

    import cimrc_pkg::*;

    logic [DATA_WIDTH-1:0]  group_count_reg;
    logic [DATA_WIDTH-1:0]  groups_done_reg, groups_done_next;
    logic [INDEX_WIDTH-1:0] saved_a_reg, saved_a_next;
    logic [INDEX_WIDTH-1:0] saved_b_reg, saved_b_next;

    logic [INDEX_WIDTH-1:0] i0, i1, i2, i3;
    logic                   e01, e12, e23, active, m0a, m0b, m1b;
    logic [DATA_WIDTH-1:0]  limit, done_inc;
    logic                   term;

    assign i0 = in_data[0*DATA_WIDTH +: INDEX_WIDTH];
    assign i1 = in_data[1*DATA_WIDTH +: INDEX_WIDTH];
    assign i2 = in_data[2*DATA_WIDTH +: INDEX_WIDTH];
    assign i3 = in_data[3*DATA_WIDTH +: INDEX_WIDTH];

    assign e01    = (i0 == i1);
    assign e12    = (i1 == i2);
    assign e23    = (i2 == i3);
    assign active = (groups_done_reg != '0);
    assign m0a    = (i0 == saved_a_reg);
    assign m0b    = (i0 == saved_b_reg);
    assign m1b    = (i1 == saved_b_reg);

    assign limit    = (group_count_reg == '0) ? DATA_WIDTH'(1) : group_count_reg;
    assign done_inc = groups_done_reg + 1'b1;
    assign term     = (done_inc >= limit);

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    assign cmd_second_a = i2;
    assign cmd_second_b = i3;

    // group classification, priority as listed
    always_comb
    begin
        cmd_ctrl.term  = term;
        cmd_ctrl.split = 1'b0;
        saved_a_next   = saved_a_reg;
        saved_b_next   = saved_b_reg;
        if (e01 && e12 && e23)
        begin
            cmd_fetch_a = i0;
            cmd_fetch_b = i0;
            cmd_ctrl.route_0 = ROUTE_A;
            cmd_ctrl.route_1 = ROUTE_A;
            cmd_ctrl.route_2 = ROUTE_A;
            cmd_ctrl.route_3 = ROUTE_A;
            saved_a_next = i0;
            saved_b_next = i0;
        end
        else if (e01 && !e12 && e23)
        begin
            cmd_fetch_a = i0;
            cmd_fetch_b = i2;
            cmd_ctrl.route_0 = ROUTE_A;
            cmd_ctrl.route_1 = ROUTE_A;
            cmd_ctrl.route_2 = ROUTE_B;
            cmd_ctrl.route_3 = ROUTE_B;
            saved_a_next = i0;
            saved_b_next = i2;
        end
        else if (!e01 && e12 && e23)
        begin
            cmd_fetch_a = i0;
            cmd_fetch_b = i2;
            cmd_ctrl.route_0 = ROUTE_A;
            cmd_ctrl.route_1 = ROUTE_B;
            cmd_ctrl.route_2 = ROUTE_B;
            cmd_ctrl.route_3 = ROUTE_B;
            saved_a_next = i0;
            saved_b_next = i2;
        end
        else if (e01 && e12 && !e23)
        begin
            cmd_fetch_a = i0;
            cmd_fetch_b = i3;
            cmd_ctrl.route_0 = ROUTE_A;
            cmd_ctrl.route_1 = ROUTE_A;
            cmd_ctrl.route_2 = ROUTE_A;
            cmd_ctrl.route_3 = ROUTE_B;
            saved_a_next = i0;
            saved_b_next = i3;
        end
        else if (active && m0a && m1b)
        begin
            cmd_fetch_a = i2;
            cmd_fetch_b = i3;
            cmd_ctrl.route_0 = ROUTE_SAVED_A;
            cmd_ctrl.route_1 = ROUTE_SAVED_B;
            cmd_ctrl.route_2 = ROUTE_A;
            cmd_ctrl.route_3 = ROUTE_B;
        end
        else if (active && e12 && m0a)
        begin
            cmd_fetch_a = i1;
            cmd_fetch_b = i3;
            cmd_ctrl.route_0 = ROUTE_SAVED_A;
            cmd_ctrl.route_1 = ROUTE_A;
            cmd_ctrl.route_2 = ROUTE_A;
            cmd_ctrl.route_3 = ROUTE_B;
            saved_b_next = i1;
        end
        else if (active && e12 && m0b)
        begin
            cmd_fetch_a = i1;
            cmd_fetch_b = i3;
            cmd_ctrl.route_0 = ROUTE_SAVED_B;
            cmd_ctrl.route_1 = ROUTE_A;
            cmd_ctrl.route_2 = ROUTE_A;
            cmd_ctrl.route_3 = ROUTE_B;
            saved_a_next = i0;
            saved_b_next = i1;
        end
        else if (active && !e12 && m0a)
        begin
            cmd_fetch_a = i1;
            cmd_fetch_b = i2;
            cmd_ctrl.route_0 = ROUTE_SAVED_A;
            cmd_ctrl.route_1 = ROUTE_A;
            cmd_ctrl.route_2 = ROUTE_B;
            cmd_ctrl.route_3 = ROUTE_B;
            saved_b_next = i1;
        end
        else if (active && !e12 && m0b)
        begin
            cmd_fetch_a = i1;
            cmd_fetch_b = i2;
            cmd_ctrl.route_0 = ROUTE_SAVED_B;
            cmd_ctrl.route_1 = ROUTE_A;
            cmd_ctrl.route_2 = ROUTE_B;
            cmd_ctrl.route_3 = ROUTE_B;
            saved_a_next = i0;
        end
        else
        begin
            cmd_fetch_a = i0;
            cmd_fetch_b = i1;
            cmd_ctrl.route_0 = ROUTE_A;
            cmd_ctrl.route_1 = ROUTE_B;
            cmd_ctrl.route_2 = ROUTE_NEXT_A;
            cmd_ctrl.route_3 = ROUTE_NEXT_B;
            cmd_ctrl.split   = 1'b1;
        end
    end

    assign groups_done_next = term ? '0 : done_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= DATA_WIDTH'(1);
            groups_done_reg <= '0;
            saved_a_reg     <= '0;
            saved_b_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                group_count_reg <= cfg_data;
            end
            if (push)
            begin
                groups_done_reg <= groups_done_next;
                saved_a_reg     <= saved_a_next;
                saved_b_reg     <= saved_b_next;
            end
        end
    end

endmodule

// ===== sv/cimrc_back.sv =====
module cimrc_back #(
    parameter int INDEX_WIDTH = cimrc_pkg::INDEX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                queue_empty,
    input  cimrc_pkg::cmd_ctrl_t                cmd_ctrl,
    input  logic [INDEX_WIDTH-1:0]              cmd_fetch_a,
    input  logic [INDEX_WIDTH-1:0]              cmd_fetch_b,
    input  logic [INDEX_WIDTH-1:0]              cmd_second_a,
    input  logic [INDEX_WIDTH-1:0]              cmd_second_b,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cimrc_pkg::M_TDATA_WIDTH-1:0] out_data,
    output logic [1:0]                          out_kind,
    output logic                                out_last
);

    import cimrc_pkg::*;

    phase_t                    phase_reg, phase_next;
    logic                      valid_reg;
    logic [M_TDATA_WIDTH-1:0]  data_reg;
    kind_t                     kind_reg;
    logic                      last_reg;

    logic                      load;
    logic                      done;
    logic [M_TDATA_WIDTH-1:0]  data_next;
    kind_t                     kind_next;
    logic                      last_next;

    assign load = !queue_empty && (!valid_reg || out_ready);
    assign pop  = load && done;

    // phase sequencing of one command
    always_comb
    begin
        phase_next = phase_reg;
        if (load)
        begin
            case (phase_reg)
                PH_GROUP:
                begin
                    if (cmd_ctrl.split)
                    begin
                        phase_next = PH_SECOND;
                    end
                    else if (cmd_ctrl.term)
                    begin
                        phase_next = PH_TERM;
                    end
                end
                PH_SECOND:
                begin
                    phase_next = cmd_ctrl.term ? PH_TERM : PH_GROUP;
                end
                PH_TERM:
                begin
                    phase_next = PH_GROUP;
                end
                default:
                begin
                    phase_next = PH_GROUP;
                end
            endcase
        end
    end

    // result payload per phase
    always_comb
    begin
        data_next = '0;
        kind_next = KIND_GROUP;
        done      = 1'b1;
        case (phase_reg)
            PH_GROUP:
            begin
                data_next = {4'd0,
                             3'(cmd_ctrl.route_3), 3'(cmd_ctrl.route_2),
                             3'(cmd_ctrl.route_1), 3'(cmd_ctrl.route_0),
                             DATA_WIDTH'(cmd_fetch_b), DATA_WIDTH'(cmd_fetch_a)};
                kind_next = KIND_GROUP;
                done      = !cmd_ctrl.split && !cmd_ctrl.term;
            end
            PH_SECOND:
            begin
                data_next = {16'd0, DATA_WIDTH'(cmd_second_b), DATA_WIDTH'(cmd_second_a)};
                kind_next = KIND_SECOND;
                done      = !cmd_ctrl.term;
            end
            PH_TERM:
            begin
                data_next = '0;
                kind_next = KIND_TERM;
                done      = 1'b1;
            end
            default:
            begin
                data_next = '0;
                kind_next = KIND_GROUP;
                done      = 1'b1;
            end
        endcase
        last_next = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_GROUP;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
            kind_reg <= kind_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

endmodule

// ===== sv/column_index_merge_reuse_control.sv =====
// a group accepted on the input is written to the queue, then loaded into the output register
// throughput: one group per cycle while the queue has room and the output is not stalled;
// a split group adds a second result, and a group that ends a run adds a terminate result
// reset: asynchronous active-low rst_n clears saved indices, group counter and queue;
// group_count resets to 1
module column_index_merge_reuse_control #(
    parameter int INDEX_WIDTH = cimrc_pkg::INDEX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = cimrc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cimrc_pkg::DATA_WIDTH-1:0]    cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // index_0, index_1, index_2, index_3
    input  logic [cimrc_pkg::S_TDATA_WIDTH-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // fetch_a, fetch_b, route_0, route_1, route_2, route_3, zero pad
    output logic [cimrc_pkg::M_TDATA_WIDTH-1:0] m_axis_tdata,
    // result_kind
    output logic [1:0]                          m_axis_tuser,
    output logic                                m_axis_tlast
);

    import cimrc_pkg::*;

    localparam int ENTRY_WIDTH = CTRL_WIDTH + 4 * INDEX_WIDTH;

    logic                   push, pop, queue_full, queue_empty;
    cmd_ctrl_t              f_ctrl, b_ctrl;
    logic [INDEX_WIDTH-1:0] f_fa, f_fb, f_sa, f_sb;
    logic [INDEX_WIDTH-1:0] b_fa, b_fb, b_sa, b_sb;
    logic [ENTRY_WIDTH-1:0] push_entry, pop_entry;

    assign cfg_ready = 1'b1;

    cimrc_front #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .in_valid     (s_axis_tvalid),
        .in_data      (s_axis_tdata),
        .in_ready     (s_axis_tready),
        .queue_full   (queue_full),
        .push         (push),
        .cmd_ctrl     (f_ctrl),
        .cmd_fetch_a  (f_fa),
        .cmd_fetch_b  (f_fb),
        .cmd_second_a (f_sa),
        .cmd_second_b (f_sb)
    );

    assign push_entry = {f_ctrl, f_fa, f_fb, f_sa, f_sb};

    cimrc_queue #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_entry),
        .empty     (queue_empty)
    );

    assign {b_ctrl, b_fa, b_fb, b_sa, b_sb} = pop_entry;

    cimrc_back #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .cmd_ctrl     (b_ctrl),
        .cmd_fetch_a  (b_fa),
        .cmd_fetch_b  (b_fb),
        .cmd_second_a (b_sa),
        .cmd_second_b (b_sb),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_kind     (m_axis_tuser),
        .out_last     (m_axis_tlast)
    );

endmodule

// ===== tb/sv/fetch_route_monitor.sv =====
`timescale 1ns / 100ps

module fetch_route_monitor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [cimrc_pkg::DATA_WIDTH-1:0]    cfg_data,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [cimrc_pkg::S_TDATA_WIDTH-1:0] s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [cimrc_pkg::M_TDATA_WIDTH-1:0] m_axis_tdata,
    input  logic [1:0]                          m_axis_tuser,
    input  logic                                m_axis_tlast,
    output int                                  pending,
    output int                                  failures
);

    import cimrc_pkg::*;

    localparam int PRINT_CAP = 200;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] fetch_a;
        logic [31:0] fetch_b;
        route_t      route_0;
        route_t      route_1;
        route_t      route_2;
        route_t      route_3;
        logic        run_end;
    } fetch_result_t;

    fetch_result_t expected_fetches [$];
    logic [31:0]   group_limit;
    logic [31:0]   last_fetch_a;
    logic [31:0]   last_fetch_b;
    logic [31:0]   groups_in_run;
    int            mismatches = 0;
    int            results_seen = 0;

    assign failures = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP)
        begin
            $display("%0t result %0d %s: got %h expected %h", $realtime, results_seen, what,
                     got, want);
        end
        mismatches++;
    endtask

    function automatic fetch_result_t make_result(input kind_t kind, input logic [31:0] fa,
                                                  input logic [31:0] fb, input route_t r0,
                                                  input route_t r1, input route_t r2,
                                                  input route_t r3);
        fetch_result_t res;
        res.kind    = kind;
        res.fetch_a = fa;
        res.fetch_b = fb;
        res.route_0 = r0;
        res.route_1 = r1;
        res.route_2 = r2;
        res.route_3 = r3;
        res.run_end = 1'b0;
        return res;
    endfunction

    task automatic predict_group(input logic [31:0] i0, input logic [31:0] i1,
                                 input logic [31:0] i2, input logic [31:0] i3);
        fetch_result_t res [3];
        int            count;
        logic          e01;
        logic          e12;
        logic          e23;
        logic          reuse_ok;
        logic [31:0]   limit;
        e01      = (i0 == i1);
        e12      = (i1 == i2);
        e23      = (i2 == i3);
        reuse_ok = (groups_in_run != 0);
        limit    = (group_limit == 0) ? 32'd1 : group_limit;
        count    = 1;
        if (e01 && e12 && e23)
        begin
            res[0] = make_result(KIND_GROUP, i0, i0, ROUTE_A, ROUTE_A, ROUTE_A, ROUTE_A);
            last_fetch_a = i0;
            last_fetch_b = i0;
        end
        else if (e01 && !e12 && e23)
        begin
            res[0] = make_result(KIND_GROUP, i0, i2, ROUTE_A, ROUTE_A, ROUTE_B, ROUTE_B);
            last_fetch_a = i0;
            last_fetch_b = i2;
        end
        else if (!e01 && e12 && e23)
        begin
            res[0] = make_result(KIND_GROUP, i0, i2, ROUTE_A, ROUTE_B, ROUTE_B, ROUTE_B);
            last_fetch_a = i0;
            last_fetch_b = i2;
        end
        else if (e01 && e12 && !e23)
        begin
            res[0] = make_result(KIND_GROUP, i0, i3, ROUTE_A, ROUTE_A, ROUTE_A, ROUTE_B);
            last_fetch_a = i0;
            last_fetch_b = i3;
        end
        else if (reuse_ok && i0 == last_fetch_a && i1 == last_fetch_b)
        begin
            res[0] = make_result(KIND_GROUP, i2, i3, ROUTE_SAVED_A, ROUTE_SAVED_B, ROUTE_A,
                                 ROUTE_B);
        end
        else if (reuse_ok && e12 && i0 == last_fetch_a)
        begin
            res[0] = make_result(KIND_GROUP, i1, i3, ROUTE_SAVED_A, ROUTE_A, ROUTE_A, ROUTE_B);
            last_fetch_b = i1;
        end
        else if (reuse_ok && e12 && i0 == last_fetch_b)
        begin
            res[0] = make_result(KIND_GROUP, i1, i3, ROUTE_SAVED_B, ROUTE_A, ROUTE_A, ROUTE_B);
            last_fetch_a = i0;
            last_fetch_b = i1;
        end
        else if (reuse_ok && !e12 && i0 == last_fetch_a)
        begin
            res[0] = make_result(KIND_GROUP, i1, i2, ROUTE_SAVED_A, ROUTE_A, ROUTE_B, ROUTE_B);
            last_fetch_b = i1;
        end
        else if (reuse_ok && !e12 && i0 == last_fetch_b)
        begin
            res[0] = make_result(KIND_GROUP, i1, i2, ROUTE_SAVED_B, ROUTE_A, ROUTE_B, ROUTE_B);
            last_fetch_a = i0;
        end
        else
        begin
            res[0] = make_result(KIND_GROUP, i0, i1, ROUTE_A, ROUTE_B, ROUTE_NEXT_A,
                                 ROUTE_NEXT_B);
            // second fetch cycle carries no routes
            res[1] = make_result(KIND_SECOND, i2, i3, ROUTE_A, ROUTE_A, ROUTE_A, ROUTE_A);
            count  = 2;
        end
        groups_in_run = groups_in_run + 32'd1;
        if (groups_in_run >= limit)
        begin
            res[count] = make_result(KIND_TERM, '0, '0, ROUTE_A, ROUTE_A, ROUTE_A, ROUTE_A);
            count++;
            groups_in_run = '0;
        end
        res[count-1].run_end = 1'b1;
        for (int k = 0; k < count; k++)
        begin
            expected_fetches.push_back(res[k]);
        end
    endtask

    task automatic check_result;
        fetch_result_t want;
        if (expected_fetches.size() == 0)
        begin
            report_mismatch("transaction with nothing expected", m_axis_tdata[31:0], '0);
        end
        else
        begin
            want = expected_fetches.pop_front();
            if (m_axis_tuser != want.kind)
                report_mismatch("result_kind", 32'(m_axis_tuser), 32'(want.kind));
            if (m_axis_tdata[31:0] != want.fetch_a)
                report_mismatch("fetch_a", m_axis_tdata[31:0], want.fetch_a);
            if (m_axis_tdata[63:32] != want.fetch_b)
                report_mismatch("fetch_b", m_axis_tdata[63:32], want.fetch_b);
            if (m_axis_tdata[66:64] != want.route_0)
                report_mismatch("route_0", 32'(m_axis_tdata[66:64]), 32'(want.route_0));
            if (m_axis_tdata[69:67] != want.route_1)
                report_mismatch("route_1", 32'(m_axis_tdata[69:67]), 32'(want.route_1));
            if (m_axis_tdata[72:70] != want.route_2)
                report_mismatch("route_2", 32'(m_axis_tdata[72:70]), 32'(want.route_2));
            if (m_axis_tdata[75:73] != want.route_3)
                report_mismatch("route_3", 32'(m_axis_tdata[75:73]), 32'(want.route_3));
            if (m_axis_tdata[79:76] != '0)
                report_mismatch("zero pad", 32'(m_axis_tdata[79:76]), '0);
            if (m_axis_tlast != want.run_end)
                report_mismatch("run_end", 32'(m_axis_tlast), 32'(want.run_end));
        end
        results_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_limit   = 32'd1;
            last_fetch_a  = '0;
            last_fetch_b  = '0;
            groups_in_run = '0;
            expected_fetches.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                group_limit = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_group(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[95:64],
                              s_axis_tdata[127:96]);
            end
            pending <= expected_fetches.size();
        end
    end

endmodule

// ===== tb/sv/column_index_merge_reuse_control_test.sv =====
`timescale 1ns / 100ps

module column_index_merge_reuse_control_test;
    import cimrc_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 80;
    localparam int IDLE_PERCENT  = 28;
    localparam int PHASES        = 10;
    localparam int PHASE_GROUPS  = 36;
    localparam int DRAIN_CYCLES  = 16;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [DATA_WIDTH-1:0]    cfg_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [S_TDATA_WIDTH-1:0] s_axis_tdata = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_axis_tdata;
    logic [1:0]               m_axis_tuser;
    logic                     m_axis_tlast;

    int          pending;
    int          failures;
    int          quiet_cycles = 0;
    logic        calm = 1'b0;
    logic        hold_request = 1'b0;
    logic [31:0] pool [4];
    int          pool_span = 3;
    logic [31:0] phase_counts [PHASES] = '{32'd2, 32'd3, 32'd1, 32'hFFFF_FFFF, 32'd2,
                                           32'd5, 32'd0, 32'd4, 32'd7, 32'd3};

    column_index_merge_reuse_control u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    fetch_route_monitor u_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .pending       (pending),
        .failures      (failures)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stalls, and one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic send_group(input logic [31:0] i0, input logic [31:0] i1,
                              input logic [31:0] i2, input logic [31:0] i3);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {i3, i2, i1, i0};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // pending is registered, so it lags the accepting edge
    task automatic settle;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_group_count(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic refresh_pool;
        for (int k = 0; k < 4; k++)
        begin
            case ($urandom_range(7))
                0:       pool[k] = '0;
                1:       pool[k] = 32'hFFFF_FFFF;
                default: pool[k] = $urandom;
            endcase
        end
        pool_span = $urandom_range(1, 3);
    endtask

    task automatic send_random_group;
        logic [31:0] lane [4];
        logic        from_pool;
        from_pool = ($urandom_range(99) < 70);
        for (int k = 0; k < 4; k++)
        begin
            lane[k] = from_pool ? pool[$urandom_range(pool_span)] : $urandom;
        end
        send_group(lane[0], lane[1], lane[2], lane[3]);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset count of one: every group is a run of its own
        send_group('0, '0, '0, '0);
        send_group(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_group(32'd5, 32'd5, 32'd9, 32'd9);
        send_group(32'd1, 32'd7, 32'd7, 32'd7);
        send_group(32'd3, 32'd3, 32'd3, 32'hFFFF_FFFF);
        send_group('0, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555);
        send_group(32'd9, 32'd5, 32'd1, 32'd2);
        settle();

        // zero count acts as one
        write_group_count('0);
        send_group(32'd1, 32'd2, 32'd3, 32'd4);
        send_group(32'd1, 32'd2, 32'd3, 32'd4);
        settle();

        // reuse against the last fetched pair
        write_group_count(32'd16);
        send_group(32'd10, 32'd10, 32'd20, 32'd20);
        send_group(32'd10, 32'd20, 32'd30, 32'd40);
        send_group(32'd10, 32'd50, 32'd50, 32'd60);
        send_group(32'd50, 32'd70, 32'd70, 32'd80);
        send_group(32'd50, 32'd90, 32'd91, 32'd92);
        send_group(32'd90, 32'd93, 32'd94, 32'd95);
        send_group(32'd1000, 32'd1001, 32'd1002, 32'd1003);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            write_group_count(phase_counts[p]);
            calm = (p == 5);
            if (p == 2)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_GROUPS; n++)
            begin
                if (n % 12 == 0)
                    refresh_pool();
                send_random_group();
            end
            settle();
        end
        calm = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cimrc_pkg.sv
sv/cimrc_queue.sv
sv/cimrc_front.sv
sv/cimrc_back.sv
sv/column_index_merge_reuse_control.sv
tb/sv/fetch_route_monitor.sv
tb/sv/column_index_merge_reuse_control_test.sv
